// File: hdl/kclp_pkg.sv
// Package for the key click and long-press detector: sizes, event codes, shared types.
`default_nettype none

package kclp_pkg;

	localparam int unsigned KEY_SLOTS    = 4;
	localparam int unsigned NUM_KEYS_DEF = 4;
	localparam int unsigned TIME_W       = 32;
	localparam int unsigned THRESH_W     = 16;
	localparam logic [THRESH_W-1:0] LONG_MS_RST = 16'd1000;

	typedef enum logic [1:0] {
		EV_NONE         = 2'd0,
		EV_CLICK        = 2'd1,
		EV_LONG         = 2'd2,
		EV_LONG_RELEASE = 2'd3
	} kclp_event_t;

	// per-key result handed back to the top level
	typedef struct packed {
		kclp_event_t event_code;
		logic        pressed;
	} kclp_key_res_t;

endpackage

`default_nettype wire

// File: hdl/key_click_long_press_detector_core.sv
// Top level of the key click and long-press detector.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction is one key scan, a
//   32-bit millisecond timestamp plus four raw active-low key levels.
//   Output channel (out_valid / out_stall): exactly one transaction per scan,
//   carrying a 2-bit event per key (none, click, long press, long release)
//   and the mask of keys pressed in that scan.
//   Config: cfg_wr_en / cfg_wr_data write the long-press threshold in ms;
//   write it only while no scan is in flight.
// Pipeline:
//   out_valid rises once the scan has passed the input register, the
//   per-key compare/subtract, then the result register.
//   Throughput is one scan per cycle while out_stall is low; per-key state
//   updates on each result load, so back-to-back scans see the prior update.
// Reset:
//   arst_n clears the pipeline valids, all key state (released, no long
//   press) and sets the threshold to 1000 ms.
// Stall:
//   While out_stall is high a full result register holds; the input register
//   keeps its scan and in_stall rises once it is full behind the result.
//   Keys at or above NUM_KEYS report no event and a zero mask bit.
`default_nettype none

module key_click_long_press_detector_core #(
	parameter int unsigned NUM_KEYS = kclp_pkg::NUM_KEYS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_wr_en,
	input  wire logic [kclp_pkg::THRESH_W-1:0]     cfg_wr_data,
	// scan input
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [kclp_pkg::TIME_W-1:0]       now_ms,
	input  wire logic                              key0_level,
	input  wire logic                              key1_level,
	input  wire logic                              key2_level,
	input  wire logic                              key3_level,
	// result output
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [1:0]                             key0_event,
	output logic [1:0]                             key1_event,
	output logic [1:0]                             key2_event,
	output logic [1:0]                             key3_event,
	output logic [kclp_pkg::KEY_SLOTS-1:0]         pressed_mask
);

	localparam int unsigned SLOTS = kclp_pkg::KEY_SLOTS;

	// threshold register
	logic [kclp_pkg::THRESH_W-1:0] long_press_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_ms_q <= kclp_pkg::LONG_MS_RST;
		end else if (cfg_wr_en) begin
			long_press_ms_q <= cfg_wr_data;
		end
	end

	// stage 1: input register
	logic                          valid_s1;
	logic [kclp_pkg::TIME_W-1:0]   now_ms_s1;
	logic [SLOTS-1:0]              level_s1;
	logic                          advance;
	logic                          load_s1;

	// stage 2: result register
	logic                          valid_s2;
	kclp_pkg::kclp_event_t [SLOTS-1:0] event_s2;
	logic [SLOTS-1:0]              mask_s2;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			now_ms_s1 <= now_ms;
			level_s1  <= {key3_level, key2_level, key1_level, key0_level};
		end
	end

	// per-key trackers; unused slots report nothing
	kclp_pkg::kclp_key_res_t [SLOTS-1:0] key_res;

	for (genvar k = 0; k < SLOTS; k++) begin : g_key
		if (k < NUM_KEYS) begin : g_used
			kclp_key_unit u_key (
				.clk           (clk),
				.arst_n        (arst_n),
				.update        (advance),
				.now_ms        (now_ms_s1),
				.level         (level_s1[k]),
				.long_press_ms (long_press_ms_q),
				.res           (key_res[k])
			);
		end else begin : g_unused
			assign key_res[k].event_code = kclp_pkg::EV_NONE;
			assign key_res[k].pressed    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < SLOTS; i++) begin
				event_s2[i] <= key_res[i].event_code;
				mask_s2[i]  <= key_res[i].pressed;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign key0_event   = event_s2[0];
	assign key1_event   = event_s2[1];
	assign key2_event   = event_s2[2];
	assign key3_event   = event_s2[3];
	assign pressed_mask = mask_s2;

endmodule

`default_nettype wire

// File: hdl/kclp_key_unit.sv
// One key's press tracker: previous state, press start time, long-press flag, event decode.
`default_nettype none

module kclp_key_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              update,
	input  wire logic [kclp_pkg::TIME_W-1:0]       now_ms,
	input  wire logic                              level,
	input  wire logic [kclp_pkg::THRESH_W-1:0]     long_press_ms,
	output kclp_pkg::kclp_key_res_t                res
);

	logic                          prev_pressed_q;
	logic [kclp_pkg::TIME_W-1:0]   press_start_q;
	logic                          long_seen_q;

	logic                          pressed;
	logic [kclp_pkg::TIME_W-1:0]   elapsed;
	logic                          reached;
	kclp_pkg::kclp_event_t         ev;
	logic                          set_long;

	assign pressed = ~level;
	// modulo 2^32 difference handles timestamp wrap
	assign elapsed = now_ms - press_start_q;
	assign reached = elapsed >= {{(kclp_pkg::TIME_W-kclp_pkg::THRESH_W){1'b0}}, long_press_ms};

	always_comb begin
		ev       = kclp_pkg::EV_NONE;
		set_long = 1'b0;
		if (pressed != prev_pressed_q) begin
			if (!pressed) begin
				ev = long_seen_q ? kclp_pkg::EV_LONG_RELEASE : kclp_pkg::EV_CLICK;
			end
		end else if (pressed && !long_seen_q && reached) begin
			ev       = kclp_pkg::EV_LONG;
			set_long = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pressed_q <= 1'b0;
			press_start_q  <= '0;
			long_seen_q    <= 1'b0;
		end else if (update) begin
			prev_pressed_q <= pressed;
			if (pressed && !prev_pressed_q) begin
				press_start_q <= now_ms;
				long_seen_q   <= 1'b0;
			end else if (set_long) begin
				long_seen_q <= 1'b1;
			end
		end
	end

	assign res.event_code = ev;
	assign res.pressed    = pressed;

endmodule

`default_nettype wire

// File: sim/key_click_long_press_detector_core_test.sv
// Self-checking testbench for the key click and long-press detector core.
`default_nettype none

module key_click_long_press_detector_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import kclp_pkg::*;

	// one report per scan: event per key plus the mask of held keys
	typedef struct packed {
		kclp_event_t [3:0] ev;
		logic [3:0]        mask;
	} scan_report_t;

	// directed row: either a threshold write or one scan
	typedef struct packed {
		bit           cfg_row;
		logic [15:0]  thr;
		logic [31:0]  now;
		logic [3:0]   lvl;
		bit           typed;
		scan_report_t exp;
	} stim_row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	localparam scan_report_t IDLE_UP     = '{'{4{EV_NONE}}, 4'h0};
	localparam scan_report_t HELD_ALL    = '{'{4{EV_NONE}}, 4'hF};
	localparam scan_report_t LONG_ALL    = '{'{4{EV_LONG}}, 4'hF};
	localparam scan_report_t LONG_UP_ALL = '{'{4{EV_LONG_RELEASE}}, 4'h0};
	localparam int           NUM_ROWS    = 26;
	localparam int           NUM_PHASES  = 7;
	localparam int           PHASE_SCANS = 150;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_wr_en    = 1'b0;
	logic [THRESH_W-1:0] cfg_wr_data  = '0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [TIME_W-1:0]   now_ms       = '0;
	logic                key0_level   = 1'b1;
	logic                key1_level   = 1'b1;
	logic                key2_level   = 1'b1;
	logic                key3_level   = 1'b1;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [1:0]          key0_event;
	logic [1:0]          key1_event;
	logic [1:0]          key2_event;
	logic [1:0]          key3_event;
	logic [KEY_SLOTS-1:0] pressed_mask;

	// predictor state, mirrors the block's per-key registers
	logic [15:0] long_ms = LONG_MS_RST;
	logic [3:0]  key_held = '0;
	logic [31:0] press_ms [4] = '{default: '0};
	logic [3:0]  long_done = '0;

	scan_report_t pending_reports [$];
	int          fail_count  = 0;
	int          burst_left  = 0;
	int          stall_cycle = 0;
	stall_mode_t stall_mode  = STALL_NONE;

	// directed scans: reset threshold first, then zero, one and the maximum
	stim_row_t stim_rows [NUM_ROWS] = '{
		'{1'b0, 16'd0,     32'd0,          4'hF, 1'b1, IDLE_UP},
		'{1'b0, 16'd0,     32'd10,         4'h0, 1'b1, HELD_ALL},
		'{1'b0, 16'd0,     32'd1009,       4'h0, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd1010,       4'h0, 1'b1, LONG_ALL},
		'{1'b0, 16'd0,     32'd5000,       4'h0, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd5001,       4'hF, 1'b1, LONG_UP_ALL},
		'{1'b0, 16'd0,     32'd6000,       4'hE, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd6001,       4'hF, 1'b0, IDLE_UP},
		// key 3 held across the timestamp wrap
		'{1'b0, 16'd0,     32'hFFFF_FE00,  4'h7, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'h0000_01E7,  4'h7, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'h0000_01E8,  4'h7, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'hFFFF_FFFF,  4'h3, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd0,          4'hF, 1'b0, IDLE_UP},
		// zero threshold: press scan stays quiet, long press on the next one
		'{1'b1, 16'd0,     32'd0,          4'hF, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd77,         4'h5, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd77,         4'h5, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd78,         4'hF, 1'b0, IDLE_UP},
		'{1'b1, 16'd1,     32'd0,          4'hF, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd200,        4'hB, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd200,        4'hB, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd201,        4'hB, 1'b0, IDLE_UP},
		'{1'b1, 16'hFFFF,  32'd0,          4'hF, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd0,          4'hD, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd65534,      4'hD, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd65535,      4'hD, 1'b0, IDLE_UP},
		'{1'b0, 16'd0,     32'd65536,      4'hF, 1'b0, IDLE_UP}
	};

	key_click_long_press_detector_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.now_ms       (now_ms),
		.key0_level   (key0_level),
		.key1_level   (key1_level),
		.key2_level   (key2_level),
		.key3_level   (key3_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key0_event   (key0_event),
		.key1_event   (key1_event),
		.key2_event   (key2_event),
		.key3_event   (key3_event),
		.pressed_mask (pressed_mask)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advances the per-key state by one scan and returns the report it causes.
	function automatic scan_report_t detect_key_events(logic [31:0] scan_ms, logic [3:0] lvl);
		scan_report_t rep;
		logic         pressed;
		logic [31:0]  held_for;
		rep = IDLE_UP;
		for (int k = 0; k < 4; k++) begin
			pressed = ~lvl[k];
			if (pressed != key_held[k]) begin
				if (pressed) begin
					press_ms[k] = scan_ms;
					long_done[k] = 1'b0;
				end else begin
					rep.ev[k] = long_done[k] ? EV_LONG_RELEASE : EV_CLICK;
				end
			end else if (pressed && !long_done[k]) begin
				held_for = scan_ms - press_ms[k];
				if (held_for >= {16'h0, long_ms}) begin
					rep.ev[k] = EV_LONG;
					long_done[k] = 1'b1;
				end
			end
			key_held[k] = pressed;
			rep.mask[k] = pressed;
		end
		return rep;
	endfunction

	// Offers one scan, waits for the transaction, then maybe ends the burst.
	task automatic send_scan(logic [31:0] scan_ms, logic [3:0] lvl, bit typed,
			scan_report_t typed_rep);
		scan_report_t rep;
		int           gap_cycles;
		in_valid   <= 1'b1;
		now_ms     <= scan_ms;
		key0_level <= lvl[0];
		key1_level <= lvl[1];
		key2_level <= lvl[2];
		key3_level <= lvl[3];
		do @(posedge clk); while (in_stall);
		rep = detect_key_events(scan_ms, lvl);
		pending_reports.push_back(typed ? typed_rep : rep);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap_cycles != 0) begin
				in_valid <= 1'b0;
				repeat (gap_cycles) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Stops sending and holds until every predicted report has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_long_press(logic [15:0] thr);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= thr;
		@(posedge clk);
		long_ms = thr;
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver backpressure: out_stall follows a stall pattern that is redrawn at random.
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		if (stall_cycle % 64 == 0)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
			STALL_PERIODIC: out_stall <= stall_cycle[2];
			default:        out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// Report checker: every transaction out is compared with the oldest prediction.
	always @(posedge clk) begin
		scan_report_t want;
		scan_report_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.ev[0] = kclp_event_t'(key0_event);
			got.ev[1] = kclp_event_t'(key1_event);
			got.ev[2] = kclp_event_t'(key2_event);
			got.ev[3] = kclp_event_t'(key3_event);
			got.mask  = pressed_mask;
			if (pending_reports.size() == 0) begin
				$display("%0t ns: report with nothing pending, events %h mask %h",
					$time, got.ev, got.mask);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				for (int k = 0; k < 4; k++) begin
					if (got.ev[k] !== want.ev[k]) begin
						$display("%0t ns: key%0d event expected %0d actual %0d",
							$time, k, want.ev[k], got.ev[k]);
						fail_count++;
					end
				end
				if (got.mask !== want.mask) begin
					$display("%0t ns: pressed_mask expected %h actual %h",
						$time, want.mask, got.mask);
					fail_count++;
				end
			end
		end
	end

	initial begin
		logic [15:0] thr;
		logic [31:0] clock_ms;
		logic [31:0] scan_ms;
		logic [3:0]  key_levels;
		int          pick;
		clock_ms   = '0;
		key_levels = 4'hF;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].cfg_row) begin
				wait_drained();
				write_long_press(stim_rows[i].thr);
			end else begin
				send_scan(stim_rows[i].now, stim_rows[i].lvl, stim_rows[i].typed,
					stim_rows[i].exp);
			end
		end

		// random phases, each under its own threshold; small time steps let
		// presses run long enough to reach the threshold
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained();
			case (phase)
				0:       thr = 16'd0;
				1:       thr = 16'd1;
				2:       thr = 16'hFFFF;
				3:       thr = 16'($urandom_range(2, 64));
				4:       thr = LONG_MS_RST;
				5:       thr = 16'($urandom_range(1, 65535));
				default: thr = 16'($urandom_range(2, 300));
			endcase
			write_long_press(thr);
			if ($urandom_range(0, 1) == 1)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * int'(thr) + 50);
			repeat (PHASE_SCANS) begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					// noise: arbitrary time and levels
					scan_ms    = $urandom();
					key_levels = 4'($urandom());
				end else begin
					if (pick < 9)
						clock_ms += $urandom();
					else
						clock_ms += $urandom_range(0, int'(thr) / 3 + 2);
					for (int k = 0; k < 4; k++)
						if ($urandom_range(0, 5) == 0)
							key_levels[k] = ~key_levels[k];
					scan_ms = clock_ms;
				end
				send_scan(scan_ms, key_levels, 1'b0, IDLE_UP);
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
hdl/kclp_pkg.sv
hdl/kclp_key_unit.sv
hdl/key_click_long_press_detector_core.sv
sim/key_click_long_press_detector_core_test.sv
